/* rtl/serial_image_update_receiver_unit_defines.svh */
// Assertion macros for the serial image-update receiver.
// Used by rtl/serial_image_update_receiver_unit.sv; expects clk and rst_n in scope.
`ifndef SERIAL_IMAGE_UPDATE_RECEIVER_UNIT_DEFINES_SVH
`define SERIAL_IMAGE_UPDATE_RECEIVER_UNIT_DEFINES_SVH

// plain property checked on every clock outside reset
`define SIUR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SIUR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/siur_pkg.sv */
// Package for the serial image-update receiver: types, codes, reset values, CRC.
// No dependencies.
`timescale 1ns / 1ps
package siur_pkg;

    localparam int DEF_CHUNK_BYTES = 256;
    localparam int RES_MAX         = 6;

    localparam logic [24:0] MAX_BYTES_RST   = 25'd131072;
    localparam logic [15:0] PROMPT_TO_RST   = 16'd1000;
    localparam logic [15:0] HEADER_TO_RST   = 16'd2000;
    localparam logic [15:0] CHUNK_TO_RST    = 16'd5000;

    localparam logic [7:0]  CH_PROMPT  = 8'h3F;
    localparam logic [7:0]  CH_REQ     = 8'h55;
    localparam logic [7:0]  CH_N       = 8'h4E;
    localparam logic [7:0]  CH_O       = 8'h4F;
    localparam logic [7:0]  CH_K       = 8'h4B;
    localparam logic [7:0]  CH_R       = 8'h52;
    localparam logic [7:0]  CH_A       = 8'h41;
    localparam logic [7:0]  HDR_MAGIC  = 8'hB2;
    localparam logic [31:0] CRC_POLY   = 32'h04C11DB7;

    typedef enum logic [1:0] {
        REG_MAX_BYTES  = 2'd0,
        REG_PROMPT_TO  = 2'd1,
        REG_HEADER_TO  = 2'd2,
        REG_CHUNK_TO   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_FLASH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        K_TX      = 2'd0,
        K_ERASE   = 2'd1,
        K_PROGRAM = 2'd2,
        K_END     = 2'd3
    } kind_t;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_WAIT_REQ = 6'b000010,
        PH_HEADER   = 6'b000100,
        PH_ERASE    = 6'b001000,
        PH_CHUNK    = 6'b010000,
        PH_PROGRAM  = 6'b100000
    } phase_t;

    localparam logic [3:0] C_VERIFIED   = 4'd0;
    localparam logic [3:0] C_NO_REPLY   = 4'd1;
    localparam logic [3:0] C_NOT_REQ    = 4'd2;
    localparam logic [3:0] C_HDR_TO     = 4'd3;
    localparam logic [3:0] C_BAD_MAGIC  = 4'd4;
    localparam logic [3:0] C_BAD_SIZE   = 4'd5;
    localparam logic [3:0] C_ERASE_FAIL = 4'd6;
    localparam logic [3:0] C_CHUNK_TO   = 4'd7;
    localparam logic [3:0] C_PROG_FAIL  = 4'd8;
    localparam logic [3:0] C_CRC_BAD    = 4'd9;

    // MSB-first CRC-32 over one word; unrolls to a flat XOR network
    function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] word);
        logic [31:0] c;
        c = crc ^ word;
        for (int i = 0; i < 32; i++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* rtl/siur_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module siur_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/serial_image_update_receiver_unit.sv */
// Serial image-update receiver: top level, session control and result queue.
// Depends on siur_pkg, siur_ram and serial_image_update_receiver_unit_defines.svh.
//
// Usage:
//   Input stream s_*: one transfer per event (start, received byte, tick,
//   flash done), op on s_tuser. Output stream m_*: result items, kind on
//   m_tuser, m_tlast marks the final result of one input transfer.
//   cfg_we/cfg_addr/cfg_wdata write the four setup registers while idle.
//   Each input transfer is processed in the cycle it is accepted and its
//   results (0 to 6) are held in a small result queue; the first result is
//   on m_* in the next cycle, the rest follow one per cycle while m_tready is high.
//   Throughput: a new input is accepted in the cycle the last queued result
//   transfers, so inputs with no or one result flow at one per cycle while
//   m_tready is high.
//   The chunk buffer is a RAM with registered read; a program command's
//   data comes from that read port or, after a same-address write, a bypass register.
//   Reset: idle phase, empty queue, registers at their defaults.
//   When m_tready is low the queue holds and s_tready drops until the
//   final queued result is taken.
`timescale 1ns / 1ps
`include "serial_image_update_receiver_unit_defines.svh"
module serial_image_update_receiver_unit #(
    parameter int CHUNK_BYTES = siur_pkg::DEF_CHUNK_BYTES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // data_byte, slot, current_version, flash_ok, zero pad
    input  logic [1:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // tx_byte, dest_slot, word_offset, word_data,
                                    // end_cause, image_size, image_crc, image_version, pad
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [24:0]  cfg_wdata
);
    import siur_pkg::*;

    localparam int CW  = CHUNK_BYTES / 4;
    localparam int CAP = CW * 4;
    localparam int LW  = $clog2(CAP + 1);
    localparam int PW  = $clog2(CW + 1);
    localparam int AW  = (CW > 1) ? $clog2(CW) : 1;

    // configuration
    logic [24:0] max_bytes_reg;
    logic [15:0] prompt_to_reg, header_to_reg, chunk_to_reg;

    // session state
    phase_t      phase_reg, phase_next;
    logic        sslot_reg, sslot_next;
    logic [15:0] wait_reg, wait_next;
    logic [3:0]  hcnt_reg, hcnt_next;
    logic [7:0]  hmagic_reg, hmagic_next;
    logic [31:0] hsize_reg, hsize_next;
    logic [31:0] hcrc_reg, hcrc_next;
    logic [31:0] hver_reg, hver_next;
    logic [24:0] rcvd_reg, rcvd_next;
    logic [LW-1:0] clen_reg, clen_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic [PW-1:0] pidx_reg, pidx_next;
    logic [31:0] crc_reg, crc_next;
    logic [23:0] asm_reg, asm_next;

    // result queue
    logic [2:0]  qcnt_reg, qcnt_n;
    logic [2:0]  qidx_reg;
    kind_t       qkind_reg [RES_MAX];
    logic [7:0]  qbyte_reg [RES_MAX];
    kind_t       qkind_n [RES_MAX];
    logic [7:0]  qbyte_n [RES_MAX];
    logic        pslot_reg, pslot_next;
    logic [23:0] poff_reg, poff_next;
    logic [3:0]  pcause_reg, pcause_next;
    logic [31:0] psize_reg, psize_next;
    logic [31:0] pcrc_reg, pcrc_next;
    logic [31:0] pver_reg, pver_next;

    // chunk RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_q, word_cur;
    logic          byp_reg;
    logic [31:0]   byp_data_reg;

    // input fields
    op_t         in_op;
    logic [7:0]  in_byte;
    logic        in_slot;
    logic [31:0] in_ver;
    logic        in_ok;

    logic s_acc, m_acc, q_last;

    assign in_op   = op_t'(s_tuser);
    assign in_byte = s_tdata[7:0];
    assign in_slot = s_tdata[8];
    assign in_ver  = s_tdata[40:9];
    assign in_ok   = s_tdata[41];

    assign m_tvalid = (qcnt_reg != 3'd0);
    assign q_last   = (qidx_reg == qcnt_reg - 3'd1);
    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = !m_tvalid || (q_last && m_tready);
    assign s_acc    = s_tvalid && s_tready;

    assign word_cur = byp_reg ? byp_data_reg : ram_q;

    siur_ram #(.WIDTH(32), .DEPTH(CW)) u_chunk_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        logic [2:0]  k;
        logic        tick_hit;
        logic [15:0] wait_inc, lim;
        logic [31:0] remain;
        logic [31:0] crc_w;
        logic [PW-1:0] pinc;
        logic [24:0] rsum;
        logic        fin_end;
        logic [3:0]  fin_cause;

        phase_next  = phase_reg;
        sslot_next  = sslot_reg;
        wait_next   = wait_reg;
        hcnt_next   = hcnt_reg;
        hmagic_next = hmagic_reg;
        hsize_next  = hsize_reg;
        hcrc_next   = hcrc_reg;
        hver_next   = hver_reg;
        rcvd_next   = rcvd_reg;
        clen_next   = clen_reg;
        fill_next   = fill_reg;
        pidx_next   = pidx_reg;
        crc_next    = crc_reg;
        asm_next    = asm_reg;
        pslot_next  = sslot_reg;
        poff_next   = 24'd0;
        pcause_next = C_VERIFIED;
        psize_next  = 32'd0;
        pcrc_next   = 32'd0;
        pver_next   = 32'd0;
        ram_we      = 1'b0;
        ram_waddr   = fill_reg[AW+1:2];
        ram_wdata   = {in_byte, asm_reg};
        k           = 3'd0;
        fin_end     = 1'b0;
        fin_cause   = C_VERIFIED;
        for (int i = 0; i < RES_MAX; i++)
        begin
            qkind_n[i] = K_TX;
            qbyte_n[i] = 8'd0;
        end

        wait_inc = (wait_reg == 16'hFFFF) ? wait_reg : wait_reg + 16'd1;
        case (phase_reg)
            PH_WAIT_REQ: lim = prompt_to_reg;
            PH_HEADER:   lim = header_to_reg;
            default:     lim = chunk_to_reg;
        endcase
        tick_hit = (wait_inc >= lim);
        crc_w    = crc_word(crc_reg, word_cur);
        pinc     = pidx_reg + PW'(1);
        rsum     = rcvd_reg + 25'(clen_reg);
        remain   = hsize_reg;

        if (s_acc)
        begin
            case (in_op)
                OP_START:
                begin
                    sslot_next  = in_slot;
                    wait_next   = 16'd0;
                    hcnt_next   = 4'd0;
                    hmagic_next = 8'd0;
                    hsize_next  = 32'd0;
                    hcrc_next   = 32'd0;
                    hver_next   = 32'd0;
                    rcvd_next   = 25'd0;
                    clen_next   = '0;
                    fill_next   = '0;
                    pidx_next   = '0;
                    crc_next    = 32'hFFFFFFFF;
                    qbyte_n[0]  = CH_PROMPT;
                    qbyte_n[1]  = in_ver[7:0];
                    qbyte_n[2]  = in_ver[15:8];
                    qbyte_n[3]  = in_ver[23:16];
                    qbyte_n[4]  = in_ver[31:24];
                    qbyte_n[5]  = {7'd0, in_slot};
                    k           = 3'd6;
                    phase_next  = PH_WAIT_REQ;
                end
                OP_BYTE:
                begin
                    case (phase_reg)
                        PH_WAIT_REQ:
                        begin
                            if (in_byte == CH_REQ)
                            begin
                                phase_next = PH_HEADER;
                                wait_next  = 16'd0;
                                hcnt_next  = 4'd0;
                            end
                            else
                            begin
                                fin_end   = 1'b1;
                                fin_cause = C_NOT_REQ;
                            end
                        end
                        PH_HEADER:
                        begin
                            case (hcnt_reg)
                                4'd0:  hmagic_next = in_byte;
                                4'd1:  hsize_next[7:0]   = in_byte;
                                4'd2:  hsize_next[15:8]  = in_byte;
                                4'd3:  hsize_next[23:16] = in_byte;
                                4'd4:  hsize_next[31:24] = in_byte;
                                4'd5:  hcrc_next[7:0]    = in_byte;
                                4'd6:  hcrc_next[15:8]   = in_byte;
                                4'd7:  hcrc_next[23:16]  = in_byte;
                                4'd8:  hcrc_next[31:24]  = in_byte;
                                4'd9:  hver_next[7:0]    = in_byte;
                                4'd10: hver_next[15:8]   = in_byte;
                                4'd11: hver_next[23:16]  = in_byte;
                                4'd12: hver_next[31:24]  = in_byte;
                                default: hmagic_next = hmagic_reg;
                            endcase
                            hcnt_next = hcnt_reg + 4'd1;
                            if (hcnt_reg == 4'd12)
                            begin
                                if (hmagic_next != HDR_MAGIC)
                                begin
                                    qbyte_n[0] = CH_N;
                                    qbyte_n[1] = CH_O;
                                    k          = 3'd2;
                                    fin_end    = 1'b1;
                                    fin_cause  = C_BAD_MAGIC;
                                end
                                else if (hsize_next == 32'd0
                                         || hsize_next > {7'd0, max_bytes_reg}
                                         || hsize_next[1:0] != 2'd0)
                                begin
                                    qbyte_n[0] = CH_N;
                                    qbyte_n[1] = CH_O;
                                    k          = 3'd2;
                                    fin_end    = 1'b1;
                                    fin_cause  = C_BAD_SIZE;
                                end
                                else
                                begin
                                    qbyte_n[0] = CH_O;
                                    qbyte_n[1] = CH_K;
                                    qkind_n[2] = K_ERASE;
                                    k          = 3'd3;
                                    phase_next = PH_ERASE;
                                end
                            end
                        end
                        PH_CHUNK:
                        begin
                            case (fill_reg[1:0])
                                2'd0:    asm_next[7:0]   = in_byte;
                                2'd1:    asm_next[15:8]  = in_byte;
                                2'd2:    asm_next[23:16] = in_byte;
                                default: ram_we = 1'b1;
                            endcase
                            fill_next = fill_reg + LW'(1);
                            if (fill_next >= clen_reg)
                            begin
                                pidx_next  = '0;
                                phase_next = PH_PROGRAM;
                                qkind_n[0] = K_PROGRAM;
                                k          = 3'd1;
                                poff_next  = rcvd_reg[23:0];
                            end
                        end
                        default: k = 3'd0;
                    endcase
                end
                OP_TICK:
                begin
                    if (phase_reg == PH_WAIT_REQ || phase_reg == PH_HEADER
                        || phase_reg == PH_CHUNK)
                    begin
                        wait_next = wait_inc;
                        if (tick_hit)
                        begin
                            fin_end = 1'b1;
                            case (phase_reg)
                                PH_WAIT_REQ: fin_cause = C_NO_REPLY;
                                PH_HEADER:   fin_cause = C_HDR_TO;
                                default:     fin_cause = C_CHUNK_TO;
                            endcase
                        end
                    end
                end
                default:
                begin
                    if (phase_reg == PH_ERASE)
                    begin
                        if (in_ok)
                        begin
                            qbyte_n[0] = CH_R;
                            k          = 3'd1;
                            rcvd_next  = 25'd0;
                            crc_next   = 32'hFFFFFFFF;
                            remain     = hsize_reg;
                            clen_next  = (remain < 32'(CAP)) ? remain[LW-1:0] : LW'(CAP);
                            fill_next  = '0;
                            pidx_next  = '0;
                            wait_next  = 16'd0;
                            phase_next = PH_CHUNK;
                        end
                        else
                        begin
                            fin_end   = 1'b1;
                            fin_cause = C_ERASE_FAIL;
                        end
                    end
                    else if (phase_reg == PH_PROGRAM)
                    begin
                        if (!in_ok)
                        begin
                            fin_end   = 1'b1;
                            fin_cause = C_PROG_FAIL;
                        end
                        else
                        begin
                            crc_next  = crc_w;
                            pidx_next = pinc;
                            if (LW'({pinc, 2'b00}) < clen_reg)
                            begin
                                qkind_n[0] = K_PROGRAM;
                                k          = 3'd1;
                                poff_next  = rcvd_reg[23:0] + 24'({pinc, 2'b00});
                            end
                            else
                            begin
                                rcvd_next  = rsum;
                                qbyte_n[0] = CH_A;
                                k          = 3'd1;
                                if ({7'd0, rsum} >= hsize_reg)
                                begin
                                    fin_end   = 1'b1;
                                    fin_cause = (crc_w == hcrc_reg) ? C_VERIFIED : C_CRC_BAD;
                                end
                                else
                                begin
                                    remain     = hsize_reg - {7'd0, rsum};
                                    clen_next  = (remain < 32'(CAP)) ? remain[LW-1:0]
                                                                     : LW'(CAP);
                                    fill_next  = '0;
                                    pidx_next  = '0;
                                    wait_next  = 16'd0;
                                    phase_next = PH_CHUNK;
                                end
                            end
                        end
                    end
                end
            endcase

            if (fin_end)
            begin
                qkind_n[k]  = K_END;
                k           = k + 3'd1;
                pcause_next = fin_cause;
                phase_next  = PH_IDLE;
                if (fin_cause != C_NO_REPLY && fin_cause != C_NOT_REQ
                    && fin_cause != C_HDR_TO)
                begin
                    psize_next = hsize_next;
                    pcrc_next  = hcrc_next;
                    pver_next  = hver_next;
                end
            end
        end

        pslot_next = sslot_next;
        qcnt_n     = k;
        ram_raddr  = pidx_next[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RST;
            prompt_to_reg <= PROMPT_TO_RST;
            header_to_reg <= HEADER_TO_RST;
            chunk_to_reg  <= CHUNK_TO_RST;
            phase_reg     <= PH_IDLE;
            sslot_reg     <= 1'b0;
            wait_reg      <= 16'd0;
            hcnt_reg      <= 4'd0;
            hmagic_reg    <= 8'd0;
            hsize_reg     <= 32'd0;
            hcrc_reg      <= 32'd0;
            hver_reg      <= 32'd0;
            rcvd_reg      <= 25'd0;
            clen_reg      <= '0;
            fill_reg      <= '0;
            pidx_reg      <= '0;
            crc_reg       <= 32'hFFFFFFFF;
            qcnt_reg      <= 3'd0;
            qidx_reg      <= 3'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_addr))
                    REG_MAX_BYTES: max_bytes_reg <= cfg_wdata;
                    REG_PROMPT_TO: prompt_to_reg <= cfg_wdata[15:0];
                    REG_HEADER_TO: header_to_reg <= cfg_wdata[15:0];
                    REG_CHUNK_TO:  chunk_to_reg  <= cfg_wdata[15:0];
                    default:       chunk_to_reg  <= chunk_to_reg;
                endcase
            end
            phase_reg  <= phase_next;
            sslot_reg  <= sslot_next;
            wait_reg   <= wait_next;
            hcnt_reg   <= hcnt_next;
            hmagic_reg <= hmagic_next;
            hsize_reg  <= hsize_next;
            hcrc_reg   <= hcrc_next;
            hver_reg   <= hver_next;
            rcvd_reg   <= rcvd_next;
            clen_reg   <= clen_next;
            fill_reg   <= fill_next;
            pidx_reg   <= pidx_next;
            crc_reg    <= crc_next;
            if (s_acc)
            begin
                qcnt_reg <= qcnt_n;
                qidx_reg <= 3'd0;
            end
            else if (m_acc)
            begin
                if (q_last)
                begin
                    qcnt_reg <= 3'd0;
                    qidx_reg <= 3'd0;
                end
                else
                begin
                    qidx_reg <= qidx_reg + 3'd1;
                end
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        asm_reg      <= asm_next;
        byp_reg      <= ram_we && (ram_waddr == ram_raddr);
        byp_data_reg <= ram_wdata;
        if (s_acc)
        begin
            for (int i = 0; i < RES_MAX; i++)
            begin
                qkind_reg[i] <= qkind_n[i];
                qbyte_reg[i] <= qbyte_n[i];
            end
            pslot_reg  <= pslot_next;
            poff_reg   <= poff_next;
            pcause_reg <= pcause_next;
            psize_reg  <= psize_next;
            pcrc_reg   <= pcrc_next;
            pver_reg   <= pver_next;
        end
    end

    kind_t out_kind;
    assign out_kind = qkind_reg[qidx_reg];
    assign m_tuser  = out_kind;
    assign m_tlast  = q_last;
    assign m_tdata  = {
        3'd0,
        (out_kind == K_END) ? pver_reg : 32'd0,
        (out_kind == K_END) ? pcrc_reg : 32'd0,
        (out_kind == K_END) ? psize_reg : 32'd0,
        (out_kind == K_END) ? pcause_reg : 4'd0,
        (out_kind == K_PROGRAM) ? word_cur : 32'd0,
        (out_kind == K_PROGRAM) ? poff_reg : 24'd0,
        (out_kind != K_TX) ? pslot_reg : 1'b0,
        qbyte_reg[qidx_reg]
    };

    `SIUR_ASSERT(a_qcnt_range, qcnt_reg <= 3'd6, "result queue count out of range")
    `SIUR_ASSERT_IMPL(a_qidx_in_range, m_tvalid, qidx_reg < qcnt_reg,
        "result index beyond queue count")
    `SIUR_ASSERT_IMPL(a_prog_index, phase_reg == PH_PROGRAM,
        LW'({pidx_reg, 2'b00}) < clen_reg, "program index beyond chunk length")
    `SIUR_ASSERT_IMPL(a_fill_bound, phase_reg == PH_CHUNK, fill_reg < clen_reg,
        "chunk fill reached length while collecting")
endmodule

/* tb/sv/serial_image_update_receiver_unit_chk.sv */
// Checker for the serial image-update receiver: watches the input, output and setup ports,
// predicts every result item from its own session model and compares field by field.
// Depends on siur_pkg.
`timescale 1ns / 1ps
module serial_image_update_receiver_unit_chk
    import siur_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [47:0]  s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [167:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [24:0]  cfg_wdata,
    output int           errors,
    output int           pending
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic        sl;
        logic [23:0] off;
        logic [31:0] wd;
        logic [3:0]  cause;
        logic [31:0] sz;
        logic [31:0] cr;
        logic [31:0] vr;
        logic        last;
    } upd_res_t;

    upd_res_t    expected_results[$];

    logic [24:0] max_bytes;
    logic [15:0] prompt_to, header_to, chunk_to;

    phase_t      ph;
    logic        sess_slot;
    logic [15:0] wait_cnt;
    logic [3:0]  hdr_cnt;
    logic [7:0]  hdr_magic;
    logic [31:0] hdr_size, hdr_crc, hdr_ver;
    logic [24:0] rx_bytes;
    logic [8:0]  chunk_len, chunk_fill;
    logic [6:0]  prog_idx;
    logic [31:0] chunk_mem [64];
    logic [31:0] image_crc;

    function automatic logic [31:0] crc32_msb(input logic [31:0] c, input logic [31:0] w);
        logic [31:0] r;
        r = c ^ w;
        for (int i = 0; i < 32; i++)
            r = r[31] ? ((r << 1) ^ 32'h04C11DB7) : (r << 1);
        return r;
    endfunction

    task automatic put(input kind_t k, input logic [7:0] tx, input logic sl,
                       input logic [23:0] off, input logic [31:0] wd, input logic [3:0] c,
                       input logic [31:0] sz, input logic [31:0] cr, input logic [31:0] vr);
        upd_res_t r;
        r = '{kind: k, tx: tx, sl: sl, off: off, wd: wd, cause: c, sz: sz, cr: cr, vr: vr,
              last: 1'b0};
        expected_results.push_back(r);
    endtask

    task automatic close_session(input logic [3:0] c);
        if (c >= C_NO_REPLY && c <= C_HDR_TO)
            put(K_END, 8'd0, sess_slot, 24'd0, 32'd0, c, 32'd0, 32'd0, 32'd0);
        else
            put(K_END, 8'd0, sess_slot, 24'd0, 32'd0, c, hdr_size, hdr_crc, hdr_ver);
        ph = PH_IDLE;
    endtask

    task automatic open_chunk();
        logic [31:0] rem;
        rem        = hdr_size - {7'd0, rx_bytes};
        chunk_len  = (rem < 32'd256) ? rem[8:0] : 9'd256;
        chunk_fill = 9'd0;
        prog_idx   = 7'd0;
        wait_cnt   = 16'd0;
        ph         = PH_CHUNK;
    endtask

    task automatic issue_word();
        logic [31:0] off;
        off = {7'd0, rx_bytes} + {23'd0, prog_idx, 2'b00};
        put(K_PROGRAM, 8'd0, sess_slot, off[23:0], chunk_mem[prog_idx[5:0]], 4'd0,
            32'd0, 32'd0, 32'd0);
    endtask

    function automatic logic tick_hit(inout logic [15:0] cnt, input logic [15:0] limit);
        if (cnt != 16'hFFFF)
            cnt = cnt + 16'd1;
        return cnt >= limit;
    endfunction

    task automatic take_header(input logic [7:0] b);
        int n;
        n = hdr_cnt;
        if (n == 0)
            hdr_magic = b;
        else if (n <= 4)
            hdr_size[8*(n-1) +: 8] = b;
        else if (n <= 8)
            hdr_crc[8*(n-5) +: 8] = b;
        else
            hdr_ver[8*(n-9) +: 8] = b;
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt < 4'd13)
            return;
        if (hdr_magic != HDR_MAGIC) begin
            put(K_TX, CH_N, 1'b0, 24'd0, 32'd0, 4'd0, 32'd0, 32'd0, 32'd0);
            put(K_TX, CH_O, 1'b0, 24'd0, 32'd0, 4'd0, 32'd0, 32'd0, 32'd0);
            close_session(C_BAD_MAGIC);
        end
        else if (hdr_size == 32'd0 || hdr_size > {7'd0, max_bytes} || hdr_size[1:0] != 2'b00)
        begin
            put(K_TX, CH_N, 1'b0, 24'd0, 32'd0, 4'd0, 32'd0, 32'd0, 32'd0);
            put(K_TX, CH_O, 1'b0, 24'd0, 32'd0, 4'd0, 32'd0, 32'd0, 32'd0);
            close_session(C_BAD_SIZE);
        end
        else begin
            put(K_TX, CH_O, 1'b0, 24'd0, 32'd0, 4'd0, 32'd0, 32'd0, 32'd0);
            put(K_TX, CH_K, 1'b0, 24'd0, 32'd0, 4'd0, 32'd0, 32'd0, 32'd0);
            put(K_ERASE, 8'd0, sess_slot, 24'd0, 32'd0, 4'd0, 32'd0, 32'd0, 32'd0);
            ph = PH_ERASE;
        end
    endtask

    task automatic advance(input op_t op, input logic [7:0] b, input logic sl,
                           input logic [31:0] v, input logic ok);
        int          n0;
        logic [5:0]  w;
        logic [4:0]  lane;
        n0 = expected_results.size();
        case (op)
            OP_START:
            begin
                sess_slot  = sl;
                wait_cnt   = 16'd0;
                hdr_cnt    = 4'd0;
                hdr_magic  = 8'd0;
                hdr_size   = 32'd0;
                hdr_crc    = 32'd0;
                hdr_ver    = 32'd0;
                rx_bytes   = 25'd0;
                chunk_len  = 9'd0;
                chunk_fill = 9'd0;
                prog_idx   = 7'd0;
                image_crc  = 32'hFFFFFFFF;
                put(K_TX, CH_PROMPT, 1'b0, 24'd0, 32'd0, 4'd0, 32'd0, 32'd0, 32'd0);
                for (int i = 0; i < 4; i++)
                    put(K_TX, v[8*i +: 8], 1'b0, 24'd0, 32'd0, 4'd0, 32'd0, 32'd0, 32'd0);
                put(K_TX, {7'd0, sl}, 1'b0, 24'd0, 32'd0, 4'd0, 32'd0, 32'd0, 32'd0);
                ph = PH_WAIT_REQ;
            end
            OP_BYTE:
            begin
                if (ph == PH_WAIT_REQ) begin
                    if (b == CH_REQ) begin
                        ph       = PH_HEADER;
                        wait_cnt = 16'd0;
                        hdr_cnt  = 4'd0;
                    end
                    else
                        close_session(C_NOT_REQ);
                end
                else if (ph == PH_HEADER)
                    take_header(b);
                else if (ph == PH_CHUNK) begin
                    w    = chunk_fill[7:2];
                    lane = {chunk_fill[1:0], 3'b000};
                    chunk_mem[w][lane +: 8] = b;
                    chunk_fill = chunk_fill + 9'd1;
                    if (chunk_fill >= chunk_len) begin
                        prog_idx = 7'd0;
                        ph       = PH_PROGRAM;
                        issue_word();
                    end
                end
            end
            OP_TICK:
            begin
                if (ph == PH_WAIT_REQ) begin
                    if (tick_hit(wait_cnt, prompt_to))
                        close_session(C_NO_REPLY);
                end
                else if (ph == PH_HEADER) begin
                    if (tick_hit(wait_cnt, header_to))
                        close_session(C_HDR_TO);
                end
                else if (ph == PH_CHUNK) begin
                    if (tick_hit(wait_cnt, chunk_to))
                        close_session(C_CHUNK_TO);
                end
            end
            default:
            begin
                if (ph == PH_ERASE) begin
                    if (ok) begin
                        put(K_TX, CH_R, 1'b0, 24'd0, 32'd0, 4'd0, 32'd0, 32'd0, 32'd0);
                        rx_bytes  = 25'd0;
                        image_crc = 32'hFFFFFFFF;
                        open_chunk();
                    end
                    else
                        close_session(C_ERASE_FAIL);
                end
                else if (ph == PH_PROGRAM) begin
                    if (!ok)
                        close_session(C_PROG_FAIL);
                    else begin
                        image_crc = crc32_msb(image_crc, chunk_mem[prog_idx[5:0]]);
                        prog_idx  = prog_idx + 7'd1;
                        if ({prog_idx, 2'b00} < {1'b0, chunk_len})
                            issue_word();
                        else begin
                            rx_bytes = rx_bytes + {16'd0, chunk_len};
                            put(K_TX, CH_A, 1'b0, 24'd0, 32'd0, 4'd0, 32'd0, 32'd0, 32'd0);
                            if ({7'd0, rx_bytes} >= hdr_size)
                                close_session((image_crc == hdr_crc) ? C_VERIFIED : C_CRC_BAD);
                            else
                                open_chunk();
                        end
                    end
                end
            end
        endcase
        if (expected_results.size() > n0)
            expected_results[expected_results.size()-1].last = 1'b1;
    endtask

    task automatic cmp(input string f, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", f, e, a);
            errors++;
        end
    endtask

    initial
    begin
        errors    = 0;
        pending   = 0;
        max_bytes = MAX_BYTES_RST;
        prompt_to = PROMPT_TO_RST;
        header_to = HEADER_TO_RST;
        chunk_to  = CHUNK_TO_RST;
        ph        = PH_IDLE;
        sess_slot = 1'b0;
        wait_cnt  = 16'd0;
        hdr_cnt   = 4'd0;
        hdr_magic = 8'd0;
        hdr_size  = 32'd0;
        hdr_crc   = 32'd0;
        hdr_ver   = 32'd0;
        rx_bytes  = 25'd0;
        chunk_len = 9'd0;
        chunk_fill = 9'd0;
        prog_idx  = 7'd0;
        image_crc = 32'hFFFFFFFF;
        for (int i = 0; i < 64; i++)
            chunk_mem[i] = 32'd0;
    end

    always @(posedge clk)
    begin
        upd_res_t e;
        if (rst_n) begin
            // outputs of this edge come from earlier inputs, so check before predicting
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer, kind %0d", m_tuser);
                    errors++;
                end
                else begin
                    e = expected_results.pop_front();
                    cmp("kind",          e.kind,  m_tuser);
                    cmp("tx_byte",       e.tx,    m_tdata[7:0]);
                    cmp("dest_slot",     e.sl,    m_tdata[8]);
                    cmp("word_offset",   e.off,   m_tdata[32:9]);
                    cmp("word_data",     e.wd,    m_tdata[64:33]);
                    cmp("end_cause",     e.cause, m_tdata[68:65]);
                    cmp("image_size",    e.sz,    m_tdata[100:69]);
                    cmp("image_crc",     e.cr,    m_tdata[132:101]);
                    cmp("image_version", e.vr,    m_tdata[164:133]);
                    cmp("last",          e.last,  m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                advance(op_t'(s_tuser), s_tdata[7:0], s_tdata[8], s_tdata[40:9], s_tdata[41]);
            if (cfg_we)
                case (cfg_reg_t'(cfg_addr))
                    REG_MAX_BYTES: max_bytes = cfg_wdata;
                    REG_PROMPT_TO: prompt_to = cfg_wdata[15:0];
                    REG_HEADER_TO: header_to = cfg_wdata[15:0];
                    default:       chunk_to  = cfg_wdata[15:0];
                endcase
            pending = expected_results.size();
        end
    end

endmodule

/* tb/sv/serial_image_update_receiver_unit_tb.sv */
// Testbench top for the serial image-update receiver: clock, reset, update-session stimulus
// under several setups, receiver stalls, watchdog and verdict.
// Depends on siur_pkg, serial_image_update_receiver_unit and serial_image_update_receiver_unit_chk.
`timescale 1ns / 1ps
module serial_image_update_receiver_unit_tb;
    import siur_pkg::*;

    typedef enum int {
        M_GOOD, M_NOT_REQ, M_NO_REPLY, M_HDR_TO, M_BAD_MAGIC, M_BAD_SIZE,
        M_ERASE_FAIL, M_CHUNK_TO, M_PROG_FAIL, M_CRC_BAD, M_RESTART
    } sess_mode_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;   // data_byte, slot, current_version, flash_ok, zero pad
    logic [1:0]   s_tuser;   // op
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;   // tx_byte, dest_slot, word_offset, word_data,
                             // end_cause, image_size, image_crc, image_version, pad
    logic [1:0]   m_tuser;   // kind
    logic         m_tlast;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [24:0]  cfg_wdata;
    int           errors;
    int           pending;

    logic         idle_en;
    int           stall_left;
    int           quiet_cycles;
    logic [15:0]  prompt_to, header_to, chunk_to;

    serial_image_update_receiver_unit dut (.*);

    serial_image_update_receiver_unit_chk chk (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (!idle_en)
            m_tready <= 1'b1;
        else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end
        else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 8);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= 5000) begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic xfer(input op_t op, input logic [7:0] b, input logic sl,
                        input logic [31:0] v, input logic ok);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, ok, v, sl, b};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_byte(input logic [7:0] b);
        xfer(OP_BYTE, b, 1'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic tick();
        xfer(OP_TICK, 8'($urandom), 1'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic flash_done(input logic ok);
        xfer(OP_FLASH, 8'($urandom), 1'($urandom), $urandom, ok);
    endtask

    // tick now and then while staying short of the running timeout
    task automatic maybe_tick(input int limit, inout int used);
        if ($urandom_range(0, 7) == 0 && used + 1 < limit) begin
            tick();
            used++;
        end
    endtask

    // ignored items while a flash operation is outstanding
    task automatic flash_noise();
        if ($urandom_range(0, 5) == 0)
            tick();
        if ($urandom_range(0, 7) == 0)
            send_byte(8'($urandom));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [24:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic setup(input logic [24:0] mx, input logic [15:0] tp, input logic [15:0] th,
                         input logic [15:0] tc);
        settle();
        prompt_to = tp;
        header_to = th;
        chunk_to  = tc;
        write_reg(REG_MAX_BYTES, mx);
        write_reg(REG_PROMPT_TO, tp);
        write_reg(REG_HEADER_TO, th);
        write_reg(REG_CHUNK_TO, tc);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic session(input sess_mode_t mode, input logic [31:0] size);
        logic [7:0]  img [$];
        logic [7:0]  hdr [13];
        logic [31:0] crc, w;
        logic [7:0]  b;
        int          used, off, len, cut;
        xfer(OP_START, 8'($urandom), 1'($urandom), $urandom, 1'($urandom));
        used = 0;
        for (int i = 0; i < 3; i++)
            maybe_tick(prompt_to, used);
        if (mode == M_NO_REPLY) begin
            repeat (prompt_to - used) tick();
            return;
        end
        if (mode == M_NOT_REQ) begin
            do
                b = 8'($urandom);
            while (b == CH_REQ);
            send_byte(b);
            return;
        end
        send_byte(CH_REQ);
        crc = 32'hFFFFFFFF;
        for (int i = 0; i < size && i < 1024; i += 4) begin
            w = $urandom;
            crc = crc_word(crc, w);
            for (int k = 0; k < 4; k++)
                img.push_back(w[8*k +: 8]);
        end
        if (mode == M_CRC_BAD)
            crc[$urandom_range(0, 31)] ^= 1'b1;
        hdr[0] = (mode == M_BAD_MAGIC) ? (HDR_MAGIC ^ (8'd1 << $urandom_range(0, 7)))
                                       : HDR_MAGIC;
        w = $urandom;
        for (int k = 0; k < 4; k++) begin
            hdr[1+k] = size[8*k +: 8];
            hdr[5+k] = crc[8*k +: 8];
            hdr[9+k] = w[8*k +: 8];
        end
        used = 0;
        cut = (mode == M_HDR_TO || mode == M_RESTART) ? $urandom_range(0, 12) : 13;
        for (int i = 0; i < cut; i++) begin
            maybe_tick(header_to, used);
            send_byte(hdr[i]);
        end
        if (mode == M_HDR_TO)
            repeat (header_to - used) tick();
        if (mode == M_HDR_TO || mode == M_RESTART || mode == M_BAD_MAGIC || mode == M_BAD_SIZE)
            return;
        flash_noise();
        flash_done(mode != M_ERASE_FAIL);
        if (mode == M_ERASE_FAIL)
            return;
        if ($urandom_range(0, 3) == 0)
            flash_done(1'($urandom));   // stray completion while a chunk is open
        off = 0;
        while (off < size) begin
            len  = (size - off < 256) ? size - off : 256;
            used = 0;
            cut  = (mode == M_CHUNK_TO) ? $urandom_range(0, len - 1) : len;
            for (int i = 0; i < cut; i++) begin
                maybe_tick(chunk_to, used);
                send_byte(img[off + i]);
            end
            if (mode == M_CHUNK_TO) begin
                repeat (chunk_to - used) tick();
                return;
            end
            for (int i = 0; i < len; i += 4) begin
                flash_noise();
                if (mode == M_PROG_FAIL && off + i + 4 >= size) begin
                    flash_done(1'b0);
                    return;
                end
                flash_done(1'b1);
            end
            off += len;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_START;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = REG_MAX_BYTES;
        cfg_wdata  = '0;
        idle_en    = 1'b1;
        stall_left = 0;
        quiet_cycles = 0;
        prompt_to  = PROMPT_TO_RST;
        header_to  = HEADER_TO_RST;
        chunk_to   = CHUNK_TO_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray items in idle
        tick();
        send_byte(CH_REQ);
        flash_done(1'b1);
        // reset setup
        session(M_GOOD, 8);
        session(M_BAD_MAGIC, 4);
        session(M_NOT_REQ, 4);
        session(M_ERASE_FAIL, 4);
        session(M_RESTART, 4);

        setup(25'd4, 16'd1, 16'd1, 16'd1);
        session(M_BAD_SIZE, 8);
        session(M_NO_REPLY, 4);
        session(M_HDR_TO, 4);
        session(M_CHUNK_TO, 4);

        setup(MAX_BYTES_RST, PROMPT_TO_RST, HEADER_TO_RST, CHUNK_TO_RST);
        idle_en = 1'b0;
        session(M_PROG_FAIL, 4);
        session(M_CRC_BAD, 4);

        settle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
